// ----- design/preemptive_priority_scheduler_core_defines.svh -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler assertion macros
// Concurrent check helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_CORE_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define PPS_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define PPS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PPS_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define PPS_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

// ----- design/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Sizes, task table entry, microcode word layout and codes.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int MAX_TASKS = 16;
   localparam int SLOT_W    = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);
   localparam int ID_W      = 5;
   localparam int TIME_W    = 32;
   localparam int ARR_W     = 16;
   localparam int BURST_W   = 16;
   localparam int PRIO_W    = 8;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [BURST_W-1:0] left;
      logic [PRIO_W-1:0]  prio;
   } pps_entry_type;

   // microcode steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_WAIT      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DISPATCH  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_LOAD      = 4'd2;
   localparam logic [STEP_W-1:0] STEP_SCAN_INIT = 4'd3;
   localparam logic [STEP_W-1:0] STEP_SCAN      = 4'd4;
   localparam logic [STEP_W-1:0] STEP_SELECT    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_RUN       = 4'd6;
   localparam logic [STEP_W-1:0] STEP_WAITCALC  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd8;
   localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd9;

   // datapath actions
   localparam int ACT_W = 4;
   localparam logic [ACT_W-1:0] ACT_NONE      = 4'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD      = 4'd1;
   localparam logic [ACT_W-1:0] ACT_SCAN_INIT = 4'd2;
   localparam logic [ACT_W-1:0] ACT_SCAN      = 4'd3;
   localparam logic [ACT_W-1:0] ACT_SELECT    = 4'd4;
   localparam logic [ACT_W-1:0] ACT_RUN       = 4'd5;
   localparam logic [ACT_W-1:0] ACT_WAITCALC  = 4'd6;
   localparam logic [ACT_W-1:0] ACT_IDLE      = 4'd7;
   localparam logic [ACT_W-1:0] ACT_EMIT      = 4'd8;

   // jump conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_NEVER       = 3'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS      = 3'd1;
   localparam logic [COND_W-1:0] COND_NO_REQ      = 3'd2;
   localparam logic [COND_W-1:0] COND_IS_TICK     = 3'd3;
   localparam logic [COND_W-1:0] COND_COUNT_ZERO  = 3'd4;
   localparam logic [COND_W-1:0] COND_MORE        = 3'd5;
   localparam logic [COND_W-1:0] COND_NOT_FOUND   = 3'd6;
   localparam logic [COND_W-1:0] COND_OUT_BLOCKED = 3'd7;

   typedef struct packed {
      logic [ACT_W-1:0]  act;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
      logic              wrap;    // fall through to the wait step
   } pps_ctrl_type;

   typedef struct packed {
      logic no_req;
      logic is_tick;
      logic count_zero;
      logic more;
      logic not_found;
      logic out_blocked;
   } pps_cond_type;

endpackage

// ----- design/pps_seq.sv -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler sequencer
// Step counter and control store with conditional jumps.
// ----------------------------------------------------------------------------
module pps_seq
   import pps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pps_cond_type flags,
   output logic [STEP_W-1:0] step,
   output pps_ctrl_type ctrl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              take_jump;

   // control store
   always_comb begin
      unique case (step_ff)
         STEP_WAIT:      ctrl = '{ACT_NONE,      COND_NO_REQ,      STEP_WAIT,      1'b0};
         STEP_DISPATCH:  ctrl = '{ACT_NONE,      COND_IS_TICK,     STEP_SCAN_INIT, 1'b0};
         STEP_LOAD:      ctrl = '{ACT_LOAD,      COND_ALWAYS,      STEP_EMIT,      1'b0};
         STEP_SCAN_INIT: ctrl = '{ACT_SCAN_INIT, COND_COUNT_ZERO,  STEP_IDLE,      1'b0};
         STEP_SCAN:      ctrl = '{ACT_SCAN,      COND_MORE,        STEP_SCAN,      1'b0};
         STEP_SELECT:    ctrl = '{ACT_SELECT,    COND_NOT_FOUND,   STEP_IDLE,      1'b0};
         STEP_RUN:       ctrl = '{ACT_RUN,       COND_NEVER,       STEP_WAIT,      1'b0};
         STEP_WAITCALC:  ctrl = '{ACT_WAITCALC,  COND_ALWAYS,      STEP_EMIT,      1'b0};
         STEP_IDLE:      ctrl = '{ACT_IDLE,      COND_NEVER,       STEP_WAIT,      1'b0};
         STEP_EMIT:      ctrl = '{ACT_EMIT,      COND_OUT_BLOCKED, STEP_EMIT,      1'b1};
         default:        ctrl = '{ACT_NONE,      COND_ALWAYS,      STEP_WAIT,      1'b0};
      endcase
   end

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:       take_jump = 1'b0;
         COND_ALWAYS:      take_jump = 1'b1;
         COND_NO_REQ:      take_jump = flags.no_req;
         COND_IS_TICK:     take_jump = flags.is_tick;
         COND_COUNT_ZERO:  take_jump = flags.count_zero;
         COND_MORE:        take_jump = flags.more;
         COND_NOT_FOUND:   take_jump = flags.not_found;
         COND_OUT_BLOCKED: take_jump = flags.out_blocked;
      endcase
   end

   always_comb begin
      priority if (take_jump) begin
         step_in = ctrl.target;
      end else if (ctrl.wrap) begin
         step_in = STEP_WAIT;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign step = step_ff;

endmodule

// ----- design/preemptive_priority_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler core
// Task table with priority pick, one unit of work per tick.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per item: req_kind selects a load (a new
//   task with arrival, burst and priority) or a tick (run one unit of work).
//   rsp_* returns exactly one transaction per item, in order.
//   A transaction moves when valid is high and stall is low.
// Steps:
//   A load passes the dispatch and load steps before its result registers
//   at the emit step. A tick scans the table one slot per cycle through the
//   single read port, then selects and updates the winner and forms the wait.
//   An idle tick skips the scan on an empty table and the update otherwise.
//   The next transaction is taken in the cycle after the result registers;
//   a result may still sit in the output register at that time.
// Reset:
//   Synchronous, active high. Clears task count, done count, time and the
//   output valid. Table contents are not cleared; slots are only read below
//   the task count.
// Stall:
//   While rsp_stall holds a result, the sequencer holds at its emit step and
//   the result register keeps its value.
// ----------------------------------------------------------------------------
`include "preemptive_priority_scheduler_core_defines.svh"

module preemptive_priority_scheduler_core
   import pps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [ARR_W-1:0]   req_arrival,
   input  logic [BURST_W-1:0] req_burst,
   input  logic [PRIO_W-1:0]  req_prio,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ID_W-1:0]    rsp_task_id,
   output logic               rsp_load_error,
   output logic               rsp_finished,
   output logic [TIME_W-1:0]  rsp_finish_time,
   output logic [TIME_W-1:0]  rsp_turnaround,
   output logic [TIME_W-1:0]  rsp_waiting,
   output logic               rsp_all_done
);

   // sequencer interface
   pps_cond_type      flags;
   pps_ctrl_type      ctrl;
   logic [STEP_W-1:0] step;

   // latched request
   logic               kind_ff;
   logic [ARR_W-1:0]   arrival_ff;
   logic [BURST_W-1:0] burst_ff;
   logic [PRIO_W-1:0]  prio_ff;
   logic               req_take;

   // task table
   pps_entry_type mem [MAX_TASKS];
   pps_entry_type rd_data_ff;
   logic          mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   pps_entry_type mem_wdata;

   // scheduler state
   logic [CNT_W-1:0]  task_count_ff, task_count_in;
   logic [CNT_W-1:0]  done_count_ff, done_count_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // scan state
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] best_ff, best_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;

   // pending result
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic              res_err_ff, res_err_in;
   logic              res_fin_ff, res_fin_in;
   logic [TIME_W-1:0] res_ft_ff, res_ft_in;
   logic [TIME_W-1:0] res_tat_ff, res_tat_in;
   logic [TIME_W-1:0] res_wt_ff, res_wt_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff;
   logic              rsp_err_ff;
   logic              rsp_fin_ff;
   logic [TIME_W-1:0] rsp_ft_ff;
   logic [TIME_W-1:0] rsp_tat_ff;
   logic [TIME_W-1:0] rsp_wt_ff;
   logic              rsp_done_ff;
   logic              emit_load;

   // helpers
   logic [CNT_W-1:0]   idx_plus;
   logic [CNT_W-1:0]   count_plus;
   logic [SLOT_W:0]    best_id;
   logic [TIME_W-1:0]  now_next;
   logic [BURST_W-1:0] left_dec;
   logic               table_full;
   logic               runnable;

   pps_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .step  (step),
      .ctrl  (ctrl)
   );

   // Accept only at the wait step; one item at a time.
   assign req_stall = (step != STEP_WAIT);
   assign req_take  = req_valid && !req_stall;

   assign idx_plus   = idx_ff + CNT_W'(1);
   assign count_plus = task_count_ff + CNT_W'(1);
   assign best_id    = {1'b0, best_ff} + {{SLOT_W{1'b0}}, 1'b1};
   assign now_next   = (now_ff == TIME_MAX) ? now_ff : now_ff + TIME_W'(1);
   assign left_dec   = rd_data_ff.left - BURST_W'(1);
   assign table_full = (task_count_ff >= CNT_W'(MAX_TASKS));
   // The memory word under evaluation belongs to slot idx_ff.
   assign runnable   = ({{(TIME_W-ARR_W){1'b0}}, rd_data_ff.arrival} <= now_ff)
                       && (rd_data_ff.left != '0);

   assign flags.no_req      = !req_valid;
   assign flags.is_tick     = (kind_ff == KIND_TICK);
   assign flags.count_zero  = (task_count_ff == '0);
   assign flags.more        = (idx_plus < task_count_ff);
   assign flags.not_found   = !found_ff;
   assign flags.out_blocked = rsp_valid_ff && rsp_stall;

   // Datapath driven by the current control word.
   always_comb begin
      task_count_in = task_count_ff;
      done_count_in = done_count_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_prio_in  = best_prio_ff;
      res_id_in     = res_id_ff;
      res_err_in    = res_err_ff;
      res_fin_in    = res_fin_ff;
      res_ft_in     = res_ft_ff;
      res_tat_in    = res_tat_ff;
      res_wt_in     = res_wt_ff;
      mem_we        = 1'b0;
      mem_waddr     = task_count_ff[SLOT_W-1:0];
      mem_wdata     = '{arrival_ff, burst_ff, burst_ff, prio_ff};

      unique case (ctrl.act)
         ACT_NONE, ACT_EMIT: begin
         end
         ACT_LOAD: begin
            res_fin_in = 1'b0;
            res_ft_in  = '0;
            res_tat_in = '0;
            res_wt_in  = '0;
            if (table_full || (burst_ff == '0)) begin
               // drop: full table or zero burst
               res_err_in = 1'b1;
               res_id_in  = '0;
            end else begin
               res_err_in    = 1'b0;
               res_id_in     = ID_W'(count_plus);
               mem_we        = 1'b1;
               task_count_in = count_plus;
            end
         end
         ACT_SCAN_INIT: begin
            idx_in   = '0;
            found_in = 1'b0;
         end
         ACT_SCAN: begin
            idx_in = idx_plus;
            // strict compare keeps the lowest slot on ties
            if (runnable && (!found_ff || (rd_data_ff.prio < best_prio_ff))) begin
               found_in     = 1'b1;
               best_in      = idx_ff[SLOT_W-1:0];
               best_prio_in = rd_data_ff.prio;
            end
         end
         ACT_SELECT: begin
            // fetch the winner's entry
            idx_in = CNT_W'(best_ff);
         end
         ACT_RUN: begin
            mem_we          = 1'b1;
            mem_waddr       = best_ff;
            mem_wdata       = rd_data_ff;
            mem_wdata.left  = left_dec;
            now_in          = now_next;
            res_id_in       = ID_W'(best_id);
            res_err_in      = 1'b0;
            if (left_dec == '0) begin
               res_fin_in    = 1'b1;
               done_count_in = done_count_ff + CNT_W'(1);
               res_ft_in     = now_next;
               res_tat_in    = now_next - {{(TIME_W-ARR_W){1'b0}}, rd_data_ff.arrival};
            end else begin
               res_fin_in = 1'b0;
               res_ft_in  = '0;
               res_tat_in = '0;
            end
         end
         ACT_WAITCALC: begin
            // waiting saturates at zero once time has saturated
            if (res_fin_ff && (res_tat_ff >= TIME_W'(rd_data_ff.burst))) begin
               res_wt_in = res_tat_ff - TIME_W'(rd_data_ff.burst);
            end else begin
               res_wt_in = '0;
            end
         end
         ACT_IDLE: begin
            now_in     = now_next;
            res_id_in  = '0;
            res_err_in = 1'b0;
            res_fin_in = 1'b0;
            res_ft_in  = '0;
            res_tat_in = '0;
            res_wt_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // Output register loads at the emit step once the slot is free.
   assign emit_load    = (ctrl.act == ACT_EMIT) && !flags.out_blocked;
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || emit_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
         done_count_ff <= '0;
         now_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         task_count_ff <= task_count_in;
         done_count_ff <= done_count_in;
         now_ff        <= now_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
      res_id_ff    <= res_id_in;
      res_err_ff   <= res_err_in;
      res_fin_ff   <= res_fin_in;
      res_ft_ff    <= res_ft_in;
      res_tat_ff   <= res_tat_in;
      res_wt_ff    <= res_wt_in;
   end

   // Capture the request payload on acceptance.
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff    <= req_kind;
         arrival_ff <= req_arrival;
         burst_ff   <= req_burst;
         prio_ff    <= req_prio;
      end
   end

   // Task table: one write port, one registered read port addressed by the
   // next scan index.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_in[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_id_ff   <= res_id_ff;
         rsp_err_ff  <= res_err_ff;
         rsp_fin_ff  <= res_fin_ff;
         rsp_ft_ff   <= res_ft_ff;
         rsp_tat_ff  <= res_tat_ff;
         rsp_wt_ff   <= res_wt_ff;
         rsp_done_ff <= (done_count_ff == task_count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_task_id     = rsp_id_ff;
   assign rsp_load_error  = rsp_err_ff;
   assign rsp_finished    = rsp_fin_ff;
   assign rsp_finish_time = rsp_ft_ff;
   assign rsp_turnaround  = rsp_tat_ff;
   assign rsp_waiting     = rsp_wt_ff;
   assign rsp_all_done    = rsp_done_ff;

   // Checks
   `PPS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
                    task_count_ff <= CNT_W'(MAX_TASKS), "task count above table size")
   `PPS_ASSERT_IMPL(a_done_bound, clock, reset, 1'b1,
                    done_count_ff <= task_count_ff, "more tasks done than loaded")
   `PPS_ASSERT_IMPL(a_fin_has_id, clock, reset, rsp_valid_ff && rsp_fin_ff,
                    (rsp_id_ff != '0) && !rsp_err_ff, "finished result without a task")
   `PPS_ASSERT_NEXT(a_time_mono, clock, reset, !reset,
                    now_ff >= $past(now_ff), "time went backwards")

endmodule
